// ===== rtl/time_of_day_step_clock_macros.svh =====
// Assertion macros shared by the time-of-day step clock RTL.
`ifndef TIME_OF_DAY_STEP_CLOCK_MACROS_SVH
`define TIME_OF_DAY_STEP_CLOCK_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TDSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("time_of_day_step_clock: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TDSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("time_of_day_step_clock: assertion failed");

`endif

// ===== rtl/tdsc_pkg.sv =====
// Types and constants of the time-of-day step clock.
package tdsc_pkg;

	localparam int TYPE_W = 2;
	localparam int MS_W   = 10;
	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 5;

	localparam int MS_PER_SEC   = 1000;
	localparam int SEC_PER_MIN  = 60;
	localparam int MIN_PER_HOUR = 60;
	localparam int HOUR_PER_DAY = 24;

	localparam logic [TYPE_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FWD  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_BACK = 2'd2;

	localparam logic [SEC_W-1:0]  SEC_MOD  = 6'd60;
	localparam logic [MIN_W-1:0]  MIN_MOD  = 6'd60;
	localparam logic [HOUR_W-1:0] HOUR_MOD = 5'd24;
	localparam logic [HOUR_W-1:0] HALF_DAY = 5'd12;
	localparam logic [MS_W-1:0]   MS_MOD   = 10'd1000;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [MS_W-1:0]   ms_amount;
		logic [SEC_W-1:0]  sec_amount;
		logic [MIN_W-1:0]  min_amount;
		logic [HOUR_W-1:0] hour_amount;
	} tdsc_req_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
		logic [MS_W-1:0]   milli;
	} tdsc_time_t;

endpackage

// ===== rtl/tdsc_if.sv =====
// Request and response channel interfaces of the time-of-day step clock.
interface tdsc_req_if;
	logic                              valid;
	logic                              ready;
	logic [tdsc_pkg::TYPE_W-1:0]       req_type;
	logic [tdsc_pkg::MS_W-1:0]         ms_amount;
	logic [tdsc_pkg::SEC_W-1:0]        sec_amount;
	logic [tdsc_pkg::MIN_W-1:0]        min_amount;
	logic [tdsc_pkg::HOUR_W-1:0]       hour_amount;

	modport source (output valid, req_type, ms_amount, sec_amount, min_amount, hour_amount,
		input ready);
	modport sink (input valid, req_type, ms_amount, sec_amount, min_amount, hour_amount,
		output ready);
endinterface

interface tdsc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tdsc_pkg::HOUR_W-1:0]       hour_24;
	logic [tdsc_pkg::HOUR_W-1:0]       display_hour;
	logic [tdsc_pkg::MIN_W-1:0]        minute_now;
	logic [tdsc_pkg::SEC_W-1:0]        second_now;
	logic [tdsc_pkg::MS_W-1:0]         milli_now;
	logic                              is_pm;

	modport source (output valid, hour_24, display_hour, minute_now, second_now, milli_now,
		is_pm, input ready);
	modport sink (input valid, hour_24, display_hour, minute_now, second_now, milli_now,
		is_pm, output ready);
endinterface

// ===== rtl/tdsc_wrap.sv =====
// One counter digit: adds or subtracts a step and folds the sum back into range.
module tdsc_wrap #(
	parameter int W   = 6,
	parameter int MOD = 60
) (
	input  logic [W-1:0] val,
	input  logic [W-1:0] amt,
	input  logic         back,
	output logic [W-1:0] res,
	output logic         wrap
);

	localparam int SW = W + 2;
	localparam logic signed [SW-1:0] POS1 = SW'(MOD);
	localparam logic signed [SW-1:0] POS2 = SW'(2 * MOD);
	localparam logic signed [SW-1:0] NEG1 = SW'(-MOD);

	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] fix;

	always_comb begin
		if (back) begin
			sum = $signed({2'b00, val}) - $signed({2'b00, amt});
		end else begin
			sum = $signed({2'b00, val}) + $signed({2'b00, amt});
		end
		if (back) begin
			if (sum < NEG1) begin
				fix = sum + POS2;
			end else if (sum[SW-1]) begin
				fix = sum + POS1;
			end else begin
				fix = sum;
			end
		end else begin
			if (sum >= POS2) begin
				fix = sum - POS2;
			end else if (sum >= POS1) begin
				fix = sum - POS1;
			end else begin
				fix = sum;
			end
		end
		res  = fix[W-1:0];
		wrap = sum[SW-1] || (sum >= POS1);
	end

endmodule

// ===== rtl/tdsc_step.sv =====
// Next-state logic: load, or a forward or backward step with a one-wrap cascade.
module tdsc_step (
	input  tdsc_pkg::tdsc_req_t  req,
	input  tdsc_pkg::tdsc_time_t cur,
	output tdsc_pkg::tdsc_time_t nxt
);

	logic                          back;
	logic [tdsc_pkg::MS_W-1:0]     ms_res;
	logic [tdsc_pkg::SEC_W-1:0]    sec_res;
	logic [tdsc_pkg::MIN_W-1:0]    min_res;
	logic [tdsc_pkg::HOUR_W-1:0]   hour_res;
	logic                          ms_wrap;
	logic                          sec_wrap;
	logic                          min_wrap;
	logic                          hour_wrap;

	assign back = (req.req_type == tdsc_pkg::REQ_BACK);

	tdsc_wrap #(.W(tdsc_pkg::MS_W), .MOD(tdsc_pkg::MS_PER_SEC)) u_ms (
		.val(cur.milli), .amt(req.ms_amount), .back(back), .res(ms_res), .wrap(ms_wrap)
	);

	tdsc_wrap #(.W(tdsc_pkg::SEC_W), .MOD(tdsc_pkg::SEC_PER_MIN)) u_sec (
		.val(cur.second), .amt(req.sec_amount), .back(back), .res(sec_res), .wrap(sec_wrap)
	);

	tdsc_wrap #(.W(tdsc_pkg::MIN_W), .MOD(tdsc_pkg::MIN_PER_HOUR)) u_min (
		.val(cur.minute), .amt(req.min_amount), .back(back), .res(min_res), .wrap(min_wrap)
	);

	tdsc_wrap #(.W(tdsc_pkg::HOUR_W), .MOD(tdsc_pkg::HOUR_PER_DAY)) u_hour (
		.val(cur.hour), .amt(req.hour_amount), .back(back), .res(hour_res),
		.wrap(hour_wrap)
	);

	always_comb begin
		nxt = cur;
		unique case (req.req_type) inside
			tdsc_pkg::REQ_LOAD: begin
				nxt.milli  = '0;
				nxt.second = (req.sec_amount >= tdsc_pkg::SEC_MOD) ?
					req.sec_amount - tdsc_pkg::SEC_MOD : req.sec_amount;
				nxt.minute = (req.min_amount >= tdsc_pkg::MIN_MOD) ?
					req.min_amount - tdsc_pkg::MIN_MOD : req.min_amount;
				nxt.hour   = (req.hour_amount >= tdsc_pkg::HOUR_MOD) ?
					req.hour_amount - tdsc_pkg::HOUR_MOD : req.hour_amount;
			end
			tdsc_pkg::REQ_FWD, tdsc_pkg::REQ_BACK: begin
				nxt.milli = ms_res;
				if (ms_wrap) begin
					nxt.second = sec_res;
				end
				if (ms_wrap && sec_wrap) begin
					nxt.minute = min_res;
				end
				if (ms_wrap && sec_wrap && min_wrap) begin
					nxt.hour = hour_res;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// The hour digit's own wrap ends the cascade and drives nothing further.
	logic unused_hour_wrap;
	assign unused_hour_wrap = hour_wrap;

endmodule

// ===== rtl/tdsc_disp.sv =====
// Hour display conversion between 24-hour and twelve-hour form with PM flag.
module tdsc_disp (
	input  logic [tdsc_pkg::HOUR_W-1:0] hour,
	input  logic                        twelve_hour_mode,
	output logic [tdsc_pkg::HOUR_W-1:0] display_hour,
	output logic                        is_pm
);

	always_comb begin
		if (!twelve_hour_mode) begin
			display_hour = hour;
		end else if (hour == '0) begin
			display_hour = tdsc_pkg::HALF_DAY;
		end else if (hour > tdsc_pkg::HALF_DAY) begin
			display_hour = hour - tdsc_pkg::HALF_DAY;
		end else begin
			display_hour = hour;
		end
		is_pm = twelve_hour_mode && (hour >= tdsc_pkg::HALF_DAY);
	end

endmodule

// ===== rtl/time_of_day_step_clock.sv =====
// Time-of-day step clock: load or step a ms/s/min/h time and return the time per transaction.
// An accepted request transaction passes through the stage-one request register and then the response register to rsp.
// Throughput is one transaction per cycle while rsp is not stalled; the time registers update in the second stage.
// A stalled response register holds both stages; req.ready is high while stage one is empty or can advance.
// Reset clears the time to 00:00:00.000, selects 24-hour display and empties both stages.
`include "time_of_day_step_clock_macros.svh"

module time_of_day_step_clock (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	tdsc_req_if.sink        req,
	tdsc_rsp_if.source      rsp
);

	logic                        valid_s1;
	tdsc_pkg::tdsc_req_t         req_s1;
	tdsc_pkg::tdsc_time_t        time_q;
	tdsc_pkg::tdsc_time_t        time_nxt;
	logic                        mode_q;
	logic                        rsp_valid_q;
	logic [tdsc_pkg::HOUR_W-1:0] disp_hour;
	logic                        disp_pm;
	logic [tdsc_pkg::HOUR_W-1:0] rsp_hour_q;
	logic [tdsc_pkg::HOUR_W-1:0] rsp_disp_q;
	logic [tdsc_pkg::MIN_W-1:0]  rsp_min_q;
	logic [tdsc_pkg::SEC_W-1:0]  rsp_sec_q;
	logic [tdsc_pkg::MS_W-1:0]   rsp_ms_q;
	logic                        rsp_pm_q;
	logic                        out_free;
	logic                        adv_s1;
	logic                        time_ok;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	tdsc_step u_step (
		.req(req_s1),
		.cur(time_q),
		.nxt(time_nxt)
	);

	tdsc_disp u_disp (
		.hour(time_nxt.hour),
		.twelve_hour_mode(mode_q),
		.display_hour(disp_hour),
		.is_pm(disp_pm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type    <= req.req_type;
			req_s1.ms_amount   <= req.ms_amount;
			req_s1.sec_amount  <= req.sec_amount;
			req_s1.min_amount  <= req.min_amount;
			req_s1.hour_amount <= req.hour_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (adv_s1) begin
			time_q <= time_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_hour_q <= time_nxt.hour;
			rsp_disp_q <= disp_hour;
			rsp_min_q  <= time_nxt.minute;
			rsp_sec_q  <= time_nxt.second;
			rsp_ms_q   <= time_nxt.milli;
			rsp_pm_q   <= disp_pm;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hour_24      = rsp_hour_q;
	assign rsp.display_hour = rsp_disp_q;
	assign rsp.minute_now   = rsp_min_q;
	assign rsp.second_now   = rsp_sec_q;
	assign rsp.milli_now    = rsp_ms_q;
	assign rsp.is_pm        = rsp_pm_q;

	assign time_ok = (time_q.milli < tdsc_pkg::MS_MOD) && (time_q.second < tdsc_pkg::SEC_MOD) &&
		(time_q.minute < tdsc_pkg::MIN_MOD) && (time_q.hour < tdsc_pkg::HOUR_MOD);

	`TDSC_ASSERT_IMP(a_time_in_range, 1'b1, time_ok)
	`TDSC_ASSERT_NXT(a_stage_moves, adv_s1, rsp_valid_q)
	`TDSC_ASSERT_IMP(a_pm_hour, rsp_valid_q && rsp_pm_q, rsp_hour_q >= tdsc_pkg::HALF_DAY)

endmodule
